// File: src/debounced_pulse_rate_meter_assert.svh
`ifndef DEBOUNCED_PULSE_RATE_METER_ASSERT_SVH
`define DEBOUNCED_PULSE_RATE_METER_ASSERT_SVH

// checks that only make sense once the block is out of reset
`define DPRM_ASSERT_RUN(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pulse rate meter check failed");

// checks that must also hold while reset is applied
`define DPRM_ASSERT_ANY(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("pulse rate meter reset check failed");

`endif

// File: src/dprm_pkg.sv
package dprm_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned BOUNCE_W  = 16;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned FRAC_W    = 16;

    // milliseconds per second, the rate scale
    localparam int unsigned SCALE_W = 10;
    localparam logic [SCALE_W-1:0] MS_PER_S = 10'd1000;

    localparam int unsigned PROD_W = 2 * TIME_W;
    localparam int unsigned A_W    = TIME_W + SCALE_W;
    localparam int unsigned NUM_W  = A_W + TIME_W;

    localparam int unsigned DIV_CNT_W = $clog2(TIME_W + 1);

    localparam logic [TIME_W-1:0] MAX32 = '1;

    localparam logic [BOUNCE_W-1:0] BOUNCE_RST   = 16'd50;
    localparam logic [TIME_W-1:0]   INTERVAL_RST = 32'd1000;
    localparam logic [TIME_W-1:0]   MULT_RST     = 32'd65536;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOUNCE   = 2'd0,
        CFG_INTERVAL = 2'd1,
        CFG_MULT     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              rise;
        logic              fold;
        logic              report;
    } t_in_item;

    typedef struct packed {
        logic [TIME_W-1:0] average_rate;
        logic [TIME_W-1:0] peak_rate;
        logic              empty_report;
    } t_out_item;

    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_queue_head;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

endpackage

// File: src/debounced_pulse_rate_meter.sv
// Debounced pulse rate meter: each input transaction carries a millisecond
// timestamp and rise, fold and report flags, handled in that order; only a
// report returns a result (average and peak rate per second, scaled by the
// multiplier register, unsigned Q16.16, saturating), and the first report
// after reset only opens the window and comes back flagged as empty. A
// two-entry queue takes transactions while the back end works on one at a
// time; a result may wait on the output stall before the next is taken. A
// fold that divides uses the shared 32-step restoring divider, and a report
// that computes rates uses it twice, after the 32x32 multiplier builds each
// 74-bit dividend in three passes. Transactions with no flag set are dropped
// at the queue.
// Configuration may be written only while the block is idle.
module debounced_pulse_rate_meter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  dprm_pkg::t_in_item               i_in_data,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output dprm_pkg::t_out_item              o_out_data,
    input  logic                             i_out_stall,
    input  logic                             i_cfg_we,
    input  logic [dprm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dprm_pkg::CFG_W-1:0]       i_cfg_data
);

    dprm_pkg::t_queue_head w_head;
    dprm_pkg::t_cfg_wr     w_cfg;
    logic                  w_pop;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    dprm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_pop      (w_pop),
        .o_head     (w_head)
    );

    dprm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: src/dprm_front.sv
module dprm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  dprm_pkg::t_in_item    i_in_data,
    output logic                  o_in_stall,
    input  logic                  i_pop,
    output dprm_pkg::t_queue_head o_head
);

    dprm_pkg::t_in_item r_mem [dprm_pkg::QDEPTH];

    logic [dprm_pkg::QPTR_W-1:0] r_wp;
    logic [dprm_pkg::QPTR_W-1:0] r_rp;
    logic [dprm_pkg::QCNT_W-1:0] r_cnt;

    logic w_accept;
    logic w_push;
    logic w_pop;

    function automatic logic [dprm_pkg::QPTR_W-1:0] ptr_next(
        input logic [dprm_pkg::QPTR_W-1:0] p
    );
        if (p == dprm_pkg::QPTR_W'(dprm_pkg::QDEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_in_stall = (r_cnt == dprm_pkg::QCNT_W'(dprm_pkg::QDEPTH));
    assign w_accept   = i_in_valid && !o_in_stall;
    // a transaction with no flag set has no effect and is dropped here
    assign w_push     = w_accept && (i_in_data.rise || i_in_data.fold || i_in_data.report);
    assign w_pop      = i_pop && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_mem[r_wp] <= i_in_data;
                r_wp        <= ptr_next(r_wp);
            end
            if (w_pop) begin
                r_rp <= ptr_next(r_rp);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: src/dprm_div.sv
module dprm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dprm_pkg::NUM_W-1:0]  i_num,
    input  logic [dprm_pkg::TIME_W-1:0] i_den,
    output logic                        o_done,
    output logic [dprm_pkg::TIME_W-1:0] o_quo
);

    localparam int unsigned TW = dprm_pkg::TIME_W;
    localparam int unsigned NW = dprm_pkg::NUM_W;

    logic                           r_busy;
    logic                           r_done;
    logic [dprm_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [TW-1:0]                  r_rem;
    logic [TW-1:0]                  r_low;
    logic [TW-1:0]                  r_quo;
    logic [TW-1:0]                  r_den;

    logic [TW:0] w_trial;
    logic [TW:0] w_diff;
    logic        w_fits;
    logic        w_sat;

    assign w_trial = {r_rem, r_low[TW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fits  = (w_trial >= {1'b0, r_den});
    // quotient overflows 32 bits exactly when the upper part reaches the divisor
    assign w_sat   = (i_num[NW-1:TW] >= {{(NW - 2 * TW){1'b0}}, i_den});

    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (w_sat) begin
                    r_quo  <= dprm_pkg::MAX32;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= dprm_pkg::DIV_CNT_W'(TW);
                    r_rem  <= i_num[2*TW-1:TW];
                    r_low  <= i_num[TW-1:0];
                    r_den  <= i_den;
                end
            end else if (r_busy) begin
                r_rem <= w_fits ? w_diff[TW-1:0] : w_trial[TW-1:0];
                r_low <= {r_low[TW-2:0], 1'b0};
                r_quo <= {r_quo[TW-2:0], w_fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == dprm_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// File: src/dprm_back.sv
module dprm_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dprm_pkg::t_cfg_wr     i_cfg,
    input  dprm_pkg::t_queue_head i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    output dprm_pkg::t_out_item   o_out_data,
    input  logic                  i_out_stall
);

    localparam int unsigned TW = dprm_pkg::TIME_W;
    localparam int unsigned AW = dprm_pkg::A_W;
    localparam int unsigned PW = dprm_pkg::PROD_W;
    localparam int unsigned NW = dprm_pkg::NUM_W;
    localparam int unsigned FW = dprm_pkg::FRAC_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE,
        S_FOLD,
        S_FOLD_WAIT,
        S_FOLD_UPD,
        S_REP,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_DIV,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    t_state r_state;

    logic [dprm_pkg::BOUNCE_W-1:0] r_bounce;
    logic [TW-1:0]                 r_interval;
    logic [TW-1:0]                 r_mult;

    logic [TW-1:0] r_last;
    logic [TW-1:0] r_pend;
    logic [TW-1:0] r_sg;
    logic [TW-1:0] r_wc;
    logic [TW-1:0] r_peak;
    logic [TW-1:0] r_ws;
    logic          r_started;

    dprm_pkg::t_in_item  r_item;
    dprm_pkg::t_out_item r_res;
    dprm_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic [TW-1:0] r_ratio;
    logic [TW-1:0] r_elapsed;
    logic          r_pk_phase;
    logic [AW-1:0] r_a;
    logic [PW-1:0] r_pl;
    logic [AW-1:0] r_ph;
    logic [NW-1:0] r_prod;

    logic [TW-1:0] w_gap;
    logic          w_edge_ok;
    logic [TW-1:0] w_sg_min;
    logic [TW-1:0] w_sg_new;
    logic [TW:0]   w_sum;
    logic [TW-1:0] w_wc_new;
    logic [TW-1:0] w_elapsed;
    logic          w_fold_div;
    logic          w_out_free;

    logic [TW-1:0] w_mul_a;
    logic [TW-1:0] w_mul_b;
    logic [PW-1:0] w_mul_p;

    logic          w_div_start;
    logic [NW-1:0] w_div_num;
    logic [TW-1:0] w_div_den;
    logic          w_div_done;
    logic [TW-1:0] w_div_quo;

    assign w_gap     = r_item.now_ms - r_last;
    assign w_edge_ok = (w_gap > {{(TW - dprm_pkg::BOUNCE_W){1'b0}}, r_bounce});
    assign w_sg_min  = (w_gap < r_sg) ? w_gap : r_sg;
    assign w_sg_new  = (w_sg_min == '0) ? TW'(1) : w_sg_min;
    assign w_sum     = {1'b0, r_wc} + {1'b0, r_pend};
    assign w_wc_new  = w_sum[TW] ? dprm_pkg::MAX32 : w_sum[TW-1:0];
    assign w_elapsed = r_item.now_ms - r_ws;
    assign w_fold_div = (r_pend != '0) && (r_sg != r_interval);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_pop       = (r_state == S_IDLE) && i_head.valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // one shared 32x32 multiplier, the wide product is built from two partials
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_MUL0: begin
                w_mul_a = r_pk_phase ? r_peak : r_wc;
                w_mul_b = {{(TW - dprm_pkg::SCALE_W){1'b0}}, dprm_pkg::MS_PER_S};
            end
            S_MUL1: begin
                w_mul_a = r_a[TW-1:0];
                w_mul_b = r_mult;
            end
            S_MUL2: begin
                w_mul_a = {{(TW - (AW - TW)){1'b0}}, r_a[AW-1:TW]};
                w_mul_b = r_mult;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = r_prod;
        w_div_den   = r_elapsed;
        if (r_state == S_FOLD) begin
            w_div_start = w_fold_div;
            w_div_num   = {{(NW - TW - FW){1'b0}}, r_interval, {FW{1'b0}}};
            w_div_den   = (r_sg == '0) ? TW'(1) : r_sg;
        end else if (r_state == S_DIV) begin
            w_div_start = 1'b1;
            // peak ratio is Q16.16, drop its fraction after scaling
            w_div_num   = r_pk_phase ? (r_prod >> FW) : r_prod;
        end
    end

    dprm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bounce    <= dprm_pkg::BOUNCE_RST;
            r_interval  <= dprm_pkg::INTERVAL_RST;
            r_mult      <= dprm_pkg::MULT_RST;
            r_last      <= '0;
            r_pend      <= '0;
            r_sg        <= dprm_pkg::INTERVAL_RST;
            r_wc        <= '0;
            r_peak      <= '0;
            r_ws        <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            r_pk_phase  <= 1'b0;
        end else begin
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    dprm_pkg::CFG_BOUNCE:   r_bounce   <= i_cfg.data[dprm_pkg::BOUNCE_W-1:0];
                    dprm_pkg::CFG_INTERVAL: r_interval <= i_cfg.data[TW-1:0];
                    dprm_pkg::CFG_MULT:     r_mult     <= i_cfg.data[TW-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_item  <= i_head.item;
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    if (r_item.rise && w_edge_ok) begin
                        if (r_pend != dprm_pkg::MAX32) begin
                            r_pend <= r_pend + 1'b1;
                        end
                        r_sg   <= w_sg_new;
                        r_last <= r_item.now_ms;
                    end
                    if (r_item.fold) begin
                        r_state <= S_FOLD;
                    end else if (r_item.report) begin
                        r_state <= S_REP;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_FOLD: begin
                    if (r_pend == '0) begin
                        r_state <= r_item.report ? S_REP : S_IDLE;
                    end else if (!w_fold_div) begin
                        // shortest gap never moved off the interval
                        r_ratio <= '0;
                        r_state <= S_FOLD_UPD;
                    end else begin
                        r_state <= S_FOLD_WAIT;
                    end
                end
                S_FOLD_WAIT: begin
                    if (w_div_done) begin
                        r_ratio <= w_div_quo;
                        r_state <= S_FOLD_UPD;
                    end
                end
                S_FOLD_UPD: begin
                    r_wc <= w_wc_new;
                    if (r_ratio > r_peak) begin
                        r_peak <= r_ratio;
                    end
                    r_sg    <= r_interval;
                    r_pend  <= '0;
                    r_state <= r_item.report ? S_REP : S_IDLE;
                end
                S_REP: begin
                    if (!r_started) begin
                        // first report only opens the window, peak is kept
                        r_started <= 1'b1;
                        r_ws      <= r_item.now_ms;
                        r_wc      <= '0;
                        r_res     <= '{average_rate: '0, peak_rate: '0, empty_report: 1'b1};
                        r_state   <= S_EMIT;
                    end else if (w_elapsed == '0) begin
                        r_res   <= '{average_rate: dprm_pkg::MAX32,
                                     peak_rate: dprm_pkg::MAX32,
                                     empty_report: 1'b0};
                        r_wc    <= '0;
                        r_peak  <= '0;
                        r_ws    <= r_item.now_ms;
                        r_state <= S_EMIT;
                    end else begin
                        r_elapsed  <= w_elapsed;
                        r_pk_phase <= 1'b0;
                        r_state    <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_a     <= w_mul_p[AW-1:0];
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_pl    <= w_mul_p;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_ph    <= w_mul_p[AW-1:0];
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_prod  <= {{{(AW - TW){1'b0}}, r_pl[PW-1:TW]} + r_ph, r_pl[TW-1:0]};
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        if (!r_pk_phase) begin
                            r_res.average_rate <= w_div_quo;
                            r_pk_phase         <= 1'b1;
                            r_state            <= S_MUL0;
                        end else begin
                            r_res.peak_rate    <= w_div_quo;
                            r_res.empty_report <= 1'b0;
                            r_wc               <= '0;
                            r_peak             <= '0;
                            r_ws               <= r_item.now_ms;
                            r_state            <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/dprm_checker.sv
`include "debounced_pulse_rate_meter_assert.svh"

module dprm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input dprm_pkg::t_out_item o_out_data,
    input logic                i_out_stall
);

    logic w_rates_zero;

    assign w_rates_zero = (o_out_data.average_rate == '0) && (o_out_data.peak_rate == '0);

    // a stalled result keeps its valid and its payload
    `DPRM_ASSERT_RUN(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))

    // the window-opening report carries no rates
    `DPRM_ASSERT_RUN(a_empty_zero, o_out_valid && o_out_data.empty_report |-> w_rates_zero)

    // reset leaves no result pending
    `DPRM_ASSERT_ANY(a_rst_out, !i_rst_n |=> !o_out_valid)

    // reset empties the queue, so input is taken right away
    `DPRM_ASSERT_ANY(a_rst_in, !i_rst_n |=> !o_in_stall)

endmodule

bind debounced_pulse_rate_meter dprm_checker u_dprm_checker (.*);

// File: dv/debounced_pulse_rate_meter_tb.sv
module debounced_pulse_rate_meter_tb;

    localparam logic [31:0]                    RATE_SAT     = 32'hFFFF_FFFF;
    localparam int unsigned                    MS_PER_SEC   = 1000;
    localparam logic [dprm_pkg::CFG_IDX_W-1:0] IDX_UNUSED   = 2'd3;
    localparam int unsigned                    DRAIN_CYCLES = 400;
    localparam int unsigned                    STALL_LIMIT  = 3000;
    localparam int unsigned                    PHASES       = 5;
    localparam int unsigned                    PHASE_EVENTS = 216;

    typedef struct {
        bit                             is_cfg;
        logic [dprm_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [dprm_pkg::CFG_W-1:0]     reg_val;
        dprm_pkg::t_in_item             ev;
        bit                             pinned;
        dprm_pkg::t_out_item            want;
    } t_step_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    dprm_pkg::t_in_item             i_in_data;
    logic                           o_in_stall;
    logic                           o_out_valid;
    dprm_pkg::t_out_item            o_out_data;
    logic                           i_out_stall;
    logic                           i_cfg_we;
    logic [dprm_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [dprm_pkg::CFG_W-1:0]     i_cfg_data;

    // mirror of the meter: registers and running state
    logic [15:0] c_bounce;
    logic [31:0] c_interval;
    logic [31:0] c_mult;
    logic [31:0] m_last_edge;
    logic [31:0] m_pending;
    logic [31:0] m_min_gap;
    logic [31:0] m_window_cnt;
    logic [31:0] m_peak;
    logic [31:0] m_win_start;
    bit          m_started;

    dprm_pkg::t_out_item rate_exp_q[$];
    bit                  pin_flag_q[$];
    dprm_pkg::t_out_item pin_val_q[$];
    t_step_row           dir_rows[$];

    int unsigned err_cnt;
    int unsigned quiet_cycles;
    bit          calm;
    logic [31:0] sim_now;

    bit                  mon_got;
    bit                  mon_pinned;
    dprm_pkg::t_out_item mon_pred;
    dprm_pkg::t_out_item mon_pin;
    dprm_pkg::t_out_item mon_want;

    debounced_pulse_rate_meter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [31:0] sat32(input logic [127:0] v);
        return (v > {96'd0, RATE_SAT}) ? RATE_SAT : v[31:0];
    endfunction

    function automatic void meter_step(input dprm_pkg::t_in_item ev, output bit got,
                                       output dprm_pkg::t_out_item res);
        logic [31:0]  gap;
        logic [31:0]  ratio;
        logic [31:0]  g;
        logic [31:0]  elapsed;
        logic [47:0]  quo;
        logic [32:0]  sum;
        logic [127:0] cnt_w;
        logic [127:0] mul_w;
        logic [127:0] num;
        got = 1'b0;
        res = '0;
        if (ev.rise) begin
            gap = ev.now_ms - m_last_edge;
            if (gap > {16'd0, c_bounce}) begin
                if (m_pending != RATE_SAT) m_pending = m_pending + 1;
                if (gap < m_min_gap) m_min_gap = gap;
                if (m_min_gap == 0) m_min_gap = 32'd1;
                m_last_edge = ev.now_ms;
            end
        end
        // a fold with nothing pending leaves everything alone
        if (ev.fold && m_pending != 0) begin
            ratio = '0;
            // no gap shorter than the interval seen: ratio stays zero
            if (m_min_gap != c_interval) begin
                g = (m_min_gap == 0) ? 32'd1 : m_min_gap;
                quo = {c_interval, 16'd0} / {16'd0, g};
                ratio = sat32({80'd0, quo});
            end
            sum = {1'b0, m_window_cnt} + {1'b0, m_pending};
            m_window_cnt = sum[32] ? RATE_SAT : sum[31:0];
            if (ratio > m_peak) m_peak = ratio;
            m_min_gap = c_interval;
            m_pending = '0;
        end
        if (!ev.report) return;
        got = 1'b1;
        if (!m_started) begin
            // opening report only starts the window
            m_started = 1'b1;
            m_win_start = ev.now_ms;
            m_window_cnt = '0;
            res.empty_report = 1'b1;
            return;
        end
        elapsed = ev.now_ms - m_win_start;
        if (elapsed == 0) begin
            res.average_rate = RATE_SAT;
            res.peak_rate = RATE_SAT;
        end else begin
            mul_w = {96'd0, c_mult};
            cnt_w = {96'd0, m_window_cnt};
            num = cnt_w * MS_PER_SEC * mul_w;
            res.average_rate = sat32(num / {96'd0, elapsed});
            cnt_w = {96'd0, m_peak};
            // peak ratio carries 16 fraction bits, dropped before the divide
            num = (cnt_w * MS_PER_SEC * mul_w) >> 16;
            res.peak_rate = sat32(num / {96'd0, elapsed});
        end
        m_window_cnt = '0;
        m_peak = '0;
        m_win_start = ev.now_ms;
    endfunction

    function automatic int unsigned draw_gap();
        if (calm || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic dprm_pkg::t_in_item next_event();
        dprm_pkg::t_in_item ev;
        int unsigned        sel;
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            sim_now = $urandom;
        end else if (sel < 12) begin
            sim_now = sim_now + $urandom_range(0, 32'h00FF_FFFF);
        end else if (sel >= 20) begin
            sim_now = sim_now + $urandom_range(0, 2 * c_bounce + 40);
        end
        ev.now_ms = sim_now;
        ev.rise = ($urandom_range(0, 99) < 80);
        ev.fold = ($urandom_range(0, 99) < 18);
        ev.report = ($urandom_range(0, 99) < 12);
        // keep flagless transactions down to occasional noise
        if ($urandom_range(0, 99) >= 4 && !(ev.rise || ev.fold || ev.report)) ev.rise = 1'b1;
        return ev;
    endfunction

    function automatic void row_in(input logic [31:0] now, input bit r, input bit f,
                                   input bit p);
        t_step_row row;
        row = '{default: '0};
        row.ev = '{now_ms: now, rise: r, fold: f, report: p};
        dir_rows.push_back(row);
    endfunction

    function automatic void row_pin(input logic [31:0] now, input bit r, input bit f,
                                    input bit p, input logic [31:0] avg,
                                    input logic [31:0] pk, input bit empty);
        t_step_row row;
        row = '{default: '0};
        row.ev = '{now_ms: now, rise: r, fold: f, report: p};
        row.pinned = 1'b1;
        row.want = '{average_rate: avg, peak_rate: pk, empty_report: empty};
        dir_rows.push_back(row);
    endfunction

    function automatic void row_cfg(input logic [dprm_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [dprm_pkg::CFG_W-1:0] val);
        t_step_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        dir_rows.push_back(row);
    endfunction

    task automatic send_event(input dprm_pkg::t_in_item ev);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= ev;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    // hold off until every expected result is back and the back end is quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (rate_exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [dprm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dprm_pkg::CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            dprm_pkg::CFG_BOUNCE:   c_bounce = val[15:0];
            dprm_pkg::CFG_INTERVAL: c_interval = val;
            dprm_pkg::CFG_MULT:     c_mult = val;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                if (rate_exp_q.size() == 0) begin
                    $error("result with no transaction pending: %0h", o_out_data);
                    err_cnt++;
                end else begin
                    mon_want = rate_exp_q.pop_front();
                    if (o_out_data.average_rate !== mon_want.average_rate) begin
                        $error("average_rate: expected %0h, got %0h",
                               mon_want.average_rate, o_out_data.average_rate);
                        err_cnt++;
                    end
                    if (o_out_data.peak_rate !== mon_want.peak_rate) begin
                        $error("peak_rate: expected %0h, got %0h",
                               mon_want.peak_rate, o_out_data.peak_rate);
                        err_cnt++;
                    end
                    if (o_out_data.empty_report !== mon_want.empty_report) begin
                        $error("empty_report: expected %0b, got %0b",
                               mon_want.empty_report, o_out_data.empty_report);
                        err_cnt++;
                    end
                end
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                meter_step(i_in_data, mon_got, mon_pred);
                if (pin_flag_q.size() != 0) begin
                    mon_pinned = pin_flag_q.pop_front();
                    mon_pin = pin_val_q.pop_front();
                    if (mon_pinned) mon_pred = mon_pin;
                end
                if (mon_got) rate_exp_q.push_back(mon_pred);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_stall === 1'b0)
                || (o_out_valid === 1'b1 && i_out_stall == 1'b0)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        i_out_stall = 1'b0;
        forever begin
            n = draw_gap();
            if (n != 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    initial begin
        t_step_row          row;
        dprm_pkg::t_in_item ev;
        int unsigned        counted;
        bit                 after_item;
        logic [15:0]        bnc;
        logic [31:0]        ivl;
        logic [31:0]        mul;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        calm = 1'b0;
        sim_now = '0;
        c_bounce = dprm_pkg::BOUNCE_RST;
        c_interval = dprm_pkg::INTERVAL_RST;
        c_mult = dprm_pkg::MULT_RST;
        m_last_edge = '0;
        m_pending = '0;
        m_min_gap = dprm_pkg::INTERVAL_RST;
        m_window_cnt = '0;
        m_peak = '0;
        m_win_start = '0;
        m_started = 1'b0;

        row_pin(32'd0, 0, 0, 1, 32'd0, 32'd0, 1);             // opening report
        row_pin(32'd0, 0, 0, 1, RATE_SAT, RATE_SAT, 0);       // zero elapsed time
        row_in(32'd100, 1, 0, 0);
        row_in(32'd120, 1, 0, 0);                             // bounce
        row_in(32'd150, 1, 0, 0);                             // gap equal to bounce time
        row_in(32'd151, 1, 0, 0);
        row_in(32'd200, 0, 1, 0);
        row_in(32'd300, 0, 1, 0);                             // nothing pending
        row_in(32'd1200, 0, 0, 1);
        row_in(32'd1300, 1, 1, 1);                            // shortest gap equals interval
        row_in(32'd1300, 0, 0, 0);
        row_cfg(IDX_UNUSED, RATE_SAT);
        row_cfg(dprm_pkg::CFG_BOUNCE, 32'd0);
        row_cfg(dprm_pkg::CFG_INTERVAL, 32'd1);
        row_cfg(dprm_pkg::CFG_MULT, RATE_SAT);
        row_in(32'hFFFF_FFF0, 1, 0, 0);
        row_in(32'hFFFF_FFF0, 1, 0, 0);                       // zero gap
        row_in(32'h0000_0010, 1, 1, 1);                       // time wraps
        row_pin(32'h0000_0011, 1, 1, 1, RATE_SAT, 32'd0, 0);
        row_cfg(dprm_pkg::CFG_INTERVAL, RATE_SAT);
        row_cfg(dprm_pkg::CFG_MULT, 32'd0);
        row_in(32'h0000_0100, 1, 1, 0);                       // ratio saturates
        row_pin(32'h0000_0200, 0, 0, 1, 32'd0, 32'd0, 0);
        row_cfg(dprm_pkg::CFG_BOUNCE, 32'h0000_FFFF);
        row_in(32'h0001_0200, 1, 0, 0);
        row_in(32'h0002_0200, 1, 0, 0);
        row_in(32'h0003_01FF, 1, 1, 1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        after_item = 1'b1;
        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.is_cfg) begin
                if (after_item) settle();
                write_reg(row.reg_idx, row.reg_val);
                after_item = 1'b0;
            end else begin
                pin_flag_q.push_back(row.pinned);
                pin_val_q.push_back(row.want);
                send_event(row.ev);
                after_item = 1'b1;
            end
        end
        sim_now = 32'h0003_01FF;

        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    bnc = 16'd0;
                    ivl = RATE_SAT;
                    mul = RATE_SAT;
                end
                1: begin
                    bnc = 16'hFFFF;
                    ivl = 32'd1;
                    mul = 32'd0;
                end
                2: begin
                    bnc = dprm_pkg::BOUNCE_RST;
                    ivl = dprm_pkg::INTERVAL_RST;
                    mul = dprm_pkg::MULT_RST;
                end
                default: begin
                    bnc = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 200));
                    ivl = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 5000)
                                                      : $urandom_range(1, RATE_SAT);
                    mul = ($urandom_range(0, 3) == 0) ? $urandom
                                                      : $urandom_range(0, 32'h0004_0000);
                end
            endcase
            write_reg(dprm_pkg::CFG_BOUNCE, {16'd0, bnc});
            write_reg(dprm_pkg::CFG_INTERVAL, ivl);
            write_reg(dprm_pkg::CFG_MULT, mul);
            calm = (ph == 2);
            counted = 0;
            while (counted < PHASE_EVENTS) begin
                ev = next_event();
                if (ev.rise || ev.fold || ev.report) counted++;
                send_event(ev);
                if ($urandom_range(0, 59) == 0) settle();
            end
        end
        calm = 1'b0;
        settle();

        if (err_cnt == 0 && rate_exp_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
